[src/psrg_pkg.sv]
// Package for the PCM splice ramp generator.
// Holds field widths, codes, queue item and result types shared by the front end, divider, back end and top level.
// No dependencies.
package psrg_pkg;

	localparam int CH_FIELD_W  = 3;
	localparam int SAMPLE_W    = 32;
	localparam int FRAMES_W    = 24;
	localparam int CHCNT_W     = 4;
	localparam int FMT_W       = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int DIFF_W      = 33;
	localparam int ERR_W       = 25;
	localparam int BYTES_W     = 3;
	localparam int FRAME_IDX_W = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 96;

	localparam logic [BYTES_W-1:0] BYTES_S16 = 3'd2;
	localparam logic [BYTES_W-1:0] BYTES_S24 = 3'd3;
	localparam logic [BYTES_W-1:0] BYTES_S32 = 3'd4;

	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_EMIT = 1'b1
	} cmd_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_S16       = 2'd0,
		FMT_S24       = 2'd1,
		FMT_S32_IN_24 = 2'd2,
		FMT_S32       = 2'd3
	} fmt_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RAMP_FRAMES   = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_SAMPLE_FORMAT = 2'd2
	} reg_index_t;

	typedef enum logic [0:0] {
		BK_IDLE = 1'b0,
		BK_DIV  = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [FRAMES_W-1:0] ramp_frames;
		logic [CHCNT_W-1:0]  channel_count;
		fmt_t                sample_format;
	} cfg_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [CH_FIELD_W-1:0] channel;
		logic [SAMPLE_W-1:0]   start_value;
		logic [DIFF_W-1:0]     diff_mag;
		logic                  diff_neg;
	} item_t;

	typedef struct packed {
		logic [CH_FIELD_W-1:0]  out_channel;
		logic [FRAME_IDX_W-1:0] frame_index;
		logic [SAMPLE_W-1:0]    sample_value;
		logic [SAMPLE_W-1:0]    packed_sample;
		logic [BYTES_W-1:0]     byte_count;
		logic                   last;
	} result_t;

endpackage

[src/psrg_front.sv]
// Front end of the splice ramp generator: accepts stream words, classifies them
// and forms the end minus start difference. Depends on psrg_pkg.
module psrg_front
	import psrg_pkg::*;
#(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 push,
	output item_t                push_item,
	input  logic                 full
);

	logic                  valid_s1;
	item_t                 item_s1;
	item_t                 item_in;
	logic                  keep;
	logic [SAMPLE_W-1:0]   start_in;
	logic [SAMPLE_W-1:0]   end_in;
	logic [DIFF_W-1:0]     diff;

	assign start_in = s_tdata[CH_FIELD_W +: SAMPLE_W];
	assign end_in   = s_tdata[CH_FIELD_W + SAMPLE_W +: SAMPLE_W];
	assign diff     = {end_in[SAMPLE_W-1], end_in} - {start_in[SAMPLE_W-1], start_in};

	always_comb begin
		item_in.cmd         = cmd_t'(s_tuser);
		item_in.channel     = s_tdata[CH_FIELD_W-1:0];
		item_in.start_value = start_in;
		item_in.diff_neg    = diff[DIFF_W-1];
		item_in.diff_mag    = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
	end

	// Loads aimed at a channel the block does not have are dropped here.
	assign keep = (item_in.cmd == CMD_EMIT) || (32'(item_in.channel) < MAX_CHANNELS);

	assign push      = valid_s1 && !full;
	assign push_item = item_s1;
	assign s_tready  = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

endmodule

[src/psrg_fifo.sv]
// Short register queue between the front end and the back end.
// Generic width and depth; depth must be a power of two. No dependencies.
module psrg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[src/psrg_div.sv]
// Restoring divider that forms the step quotient and remainder of a ramp load,
// one quotient bit per cycle. Depends on psrg_pkg.
module psrg_div
	import psrg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIFF_W-1:0]   dividend,
	input  logic [FRAMES_W-1:0] divisor,
	output logic                done,
	output logic [SAMPLE_W-1:0] quotient,
	output logic [FRAMES_W-1:0] remainder
);

	localparam int STEPS = DIFF_W;
	localparam int CNT_W = $clog2(STEPS);

	logic [DIFF_W-1:0]   quo_q;
	logic [FRAMES_W-1:0] rem_q;
	logic [FRAMES_W-1:0] dvs_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [FRAMES_W:0]   trial;
	logic                ge;
	logic [FRAMES_W:0]   diff;

	assign trial = {rem_q, quo_q[DIFF_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	assign done      = done_q;
	assign quotient  = quo_q[SAMPLE_W-1:0];
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIFF_W-2:0], ge};
			rem_q <= ge ? diff[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
		end
	end

endmodule

[src/psrg_back.sv]
// Back end of the splice ramp generator: per-channel ramp state, load sequencing
// through the divider, sample stepping and format packing. Depends on psrg_pkg, psrg_div.
module psrg_back
	import psrg_pkg::*;
#(
	parameter int MAX_CHANNELS = 8,
	parameter int FRAME_BITS   = 24
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fifo_empty,
	input  item_t   fifo_item,
	output logic    pop,
	output logic    res_valid,
	output result_t res,
	input  logic    res_ready
);

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [SAMPLE_W-1:0]   level_q [MAX_CHANNELS];
	logic [SAMPLE_W-1:0]   quot_q  [MAX_CHANNELS];
	logic [ERR_W-1:0]      err_q   [MAX_CHANNELS];
	logic [FRAMES_W-1:0]   inc_q   [MAX_CHANNELS];
	logic                  dir_q   [MAX_CHANNELS];

	back_state_t           state_q;
	back_state_t           state_n;
	logic [FRAME_BITS-1:0] frame_q;
	logic [CH_W-1:0]       chan_q;
	logic                  ramp_done_q;
	logic [CH_W-1:0]       ld_ch_q;
	logic [SAMPLE_W-1:0]   ld_start_q;
	logic                  ld_neg_q;
	logic [FRAMES_W-1:0]   n_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic                  head_emit;
	logic                  out_free;
	logic                  div_start;
	logic                  div_done;
	logic                  emit_go;
	logic                  commit;
	logic [SAMPLE_W-1:0]   div_quo;
	logic [FRAMES_W-1:0]   div_rem;
	logic [SAMPLE_W-1:0]   step_q;

	logic [FRAMES_W-1:0]   n_cur;
	logic [CH_W:0]         nch;
	logic                  chan_last;
	logic                  frame_last;
	logic                  is_last;
	logic [SAMPLE_W-1:0]   lv;
	logic [ERR_W:0]        e_sub;
	logic                  adj;
	logic [SAMPLE_W-1:0]   adj_val;
	logic [SAMPLE_W-1:0]   lv_next;
	logic [ERR_W:0]        e_next;
	result_t               res_next;

	psrg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (fifo_item.diff_mag),
		.divisor   (n_cur),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign n_cur = (cfg.ramp_frames == '0) ? FRAMES_W'(1) : cfg.ramp_frames;

	always_comb begin
		if (cfg.channel_count == '0) begin
			nch = (CH_W + 1)'(1);
		end else if (32'(cfg.channel_count) > MAX_CHANNELS) begin
			nch = (CH_W + 1)'(MAX_CHANNELS);
		end else begin
			nch = (CH_W + 1)'(cfg.channel_count);
		end
	end

	assign chan_last  = ({1'b0, chan_q} + 1'b1) >= nch;
	assign frame_last = (32'(frame_q) + 32'd1) >= 32'(n_cur);
	assign is_last    = frame_last && chan_last;

	// Bresenham step: quotient every sample, one extra unit when the error runs out.
	assign lv      = level_q[chan_q];
	assign e_sub   = {err_q[chan_q][ERR_W-1], err_q[chan_q]} - (ERR_W + 1)'(inc_q[chan_q]);
	assign adj     = e_sub[ERR_W];
	assign adj_val = adj ? (dir_q[chan_q] ? SAMPLE_W'(1) : '1) : '0;
	assign lv_next = lv + quot_q[chan_q] + adj_val;
	assign e_next  = adj ? e_sub + (ERR_W + 1)'(n_cur) : e_sub;

	assign step_q  = ld_neg_q ? (~div_quo + 1'b1) : div_quo;

	always_comb begin
		res_next.out_channel  = CH_FIELD_W'(chan_q);
		res_next.frame_index  = FRAME_IDX_W'(frame_q);
		res_next.sample_value = lv;
		res_next.last         = is_last;
		case (cfg.sample_format)
			FMT_S16: begin
				res_next.packed_sample = {16'b0, lv[15:0]};
				res_next.byte_count    = BYTES_S16;
			end
			FMT_S24: begin
				res_next.packed_sample = {8'b0, lv[23:0]};
				res_next.byte_count    = BYTES_S24;
			end
			FMT_S32_IN_24: begin
				res_next.packed_sample = {lv[23:0], 8'b0};
				res_next.byte_count    = BYTES_S32;
			end
			default: begin
				res_next.packed_sample = lv;
				res_next.byte_count    = BYTES_S32;
			end
		endcase
	end

	assign head_emit = (fifo_item.cmd == CMD_EMIT);
	assign out_free  = !out_valid_q || res_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_empty && !head_emit) begin
					state_n = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_done) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		emit_go   = 1'b0;
		commit    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_empty) begin
					if (!head_emit) begin
						pop       = 1'b1;
						div_start = 1'b1;
					end else if (ramp_done_q) begin
						pop = 1'b1;
					end else if (out_free) begin
						pop     = 1'b1;
						emit_go = 1'b1;
					end
				end
			end
			BK_DIV: begin
				commit = div_done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			frame_q     <= '0;
			chan_q      <= '0;
			ramp_done_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (commit) begin
				frame_q     <= '0;
				chan_q      <= '0;
				ramp_done_q <= 1'b0;
			end else if (emit_go) begin
				if (is_last) begin
					ramp_done_q <= 1'b1;
				end else if (chan_last) begin
					chan_q  <= '0;
					frame_q <= frame_q + 1'b1;
				end else begin
					chan_q <= chan_q + 1'b1;
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			ld_ch_q    <= CH_W'(fifo_item.channel);
			ld_start_q <= fifo_item.start_value;
			ld_neg_q   <= fifo_item.diff_neg;
			n_q        <= n_cur;
		end
		if (emit_go) begin
			out_q <= res_next;
		end
		if (commit) begin
			level_q[ld_ch_q] <= ld_start_q;
			quot_q[ld_ch_q]  <= step_q;
			inc_q[ld_ch_q]   <= div_rem;
			dir_q[ld_ch_q]   <= !ld_neg_q;
			err_q[ld_ch_q]   <= ERR_W'(n_q >> 1);
		end else if (emit_go) begin
			level_q[chan_q] <= lv_next;
			err_q[chan_q]   <= e_next[ERR_W-1:0];
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

[src/pcm_splice_ramp_generator.sv]
// PCM splice ramp generator, top level: configuration registers, stream ports.
// Emit words pass the front register, queue and output register, one per cycle
// while the output is ready and no load is in the back end. A load holds the back end
// through issue, the 33-step divider and commit; later words queue behind it. Reset
// clears control state, loads register defaults; per-channel ramp state is undefined until
// its channel is loaded. Depends on psrg_pkg, psrg_front, psrg_fifo, psrg_back.
module pcm_splice_ramp_generator
	import psrg_pkg::*;
#(
	parameter int MAX_CHANNELS = 8,
	parameter int FRAME_BITS   = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// channel, start_value, end_value, zero fill
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// cmd
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_channel, frame_index, sample_value, packed_sample, byte_count, zero fill
	output logic [OUT_DATA_W-1:0]  m_tdata,
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t    cfg_q;
	logic    push;
	item_t   push_item;
	logic    full;
	logic    pop;
	item_t   pop_item;
	logic    empty;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_frames   <= FRAMES_W'(1);
			cfg_q.channel_count <= CHCNT_W'(2);
			cfg_q.sample_format <= FMT_S16;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_RAMP_FRAMES:   cfg_q.ramp_frames   <= cfg_wdata[FRAMES_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_wdata[CHCNT_W-1:0];
				REG_SAMPLE_FORMAT: cfg_q.sample_format <= fmt_t'(cfg_wdata[FMT_W-1:0]);
				default: ;
			endcase
		end
	end

	psrg_front #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	psrg_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_item),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_item),
		.empty     (empty)
	);

	psrg_back #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.FRAME_BITS   (FRAME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_empty (empty),
		.fifo_item  (pop_item),
		.pop        (pop),
		.res_valid  (m_tvalid),
		.res        (res),
		.res_ready  (m_tready)
	);

	assign m_tdata = {2'b0, res.byte_count, res.packed_sample, res.sample_value,
		res.frame_index, res.out_channel};
	assign m_tlast = res.last;

endmodule

[sim/tb_pcm_splice_ramp_generator.sv]
// Testbench for pcm_splice_ramp_generator: checks each emitted ramp word against a predictor
// written in this file. It drives directed and random stream traffic with random stalls.
// Depends on psrg_pkg and the RTL under src.
module tb_pcm_splice_ramp_generator;
	import psrg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CH = 8;
	localparam int SETTLE_CYCLES = 600;
	localparam int RANDOM_WORDS = 900;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Register copies and per-channel ramp state of the predictor.
	logic [23:0]        frames_reg;
	logic [3:0]         chans_reg;
	fmt_t               fmt_reg;
	logic [31:0]        lvl [MAX_CH];
	logic signed [32:0] quot [MAX_CH];
	logic signed [24:0] err [MAX_CH];
	logic [23:0]        incr [MAX_CH];
	bit                 dir [MAX_CH];
	logic [23:0]        frame_ctr;
	int unsigned        ch_ctr;
	bit                 done;

	result_t     pending_samples[$];
	int unsigned mismatches;
	int unsigned words_sent;
	bit          src_calm;
	bit          snk_calm;

	pcm_splice_ramp_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic bit ramp_next_sample(input cmd_t cmd, input logic [2:0] chan,
			input logic [31:0] start_v, input logic [31:0] end_v, output result_t r);
		longint n, d, q, mag, e;
		logic [31:0] v;
		int unsigned nch, ch;
		bit is_last;
		r = '0;
		n = (frames_reg == 0) ? 1 : longint'(frames_reg);
		if (cmd == CMD_LOAD) begin
			d = longint'($signed(end_v)) - longint'($signed(start_v));
			q = d / n;
			mag = (d < 0) ? -d : d;
			lvl[chan] = start_v;
			quot[chan] = q[32:0];
			incr[chan] = 24'(mag % n);
			dir[chan] = (d >= 0);
			err[chan] = 25'(n / 2);
			frame_ctr = '0;
			ch_ctr = 0;
			done = 1'b0;
			return 1'b0;
		end
		if (done)
			return 1'b0;
		nch = (chans_reg == 0) ? 1 : (chans_reg > MAX_CH) ? MAX_CH : chans_reg;
		ch = ch_ctr % MAX_CH;
		v = lvl[ch];
		is_last = (longint'(frame_ctr) + 1 >= n) && (ch_ctr + 1 >= nch);
		r.out_channel = ch[2:0];
		r.frame_index = frame_ctr;
		r.sample_value = v;
		r.last = is_last;
		case (fmt_reg)
			FMT_S16: begin
				r.packed_sample = {16'h0, v[15:0]};
				r.byte_count = BYTES_S16;
			end
			FMT_S24: begin
				r.packed_sample = {8'h0, v[23:0]};
				r.byte_count = BYTES_S24;
			end
			FMT_S32_IN_24: begin
				r.packed_sample = {v[23:0], 8'h0};
				r.byte_count = BYTES_S32;
			end
			default: begin
				r.packed_sample = v;
				r.byte_count = BYTES_S32;
			end
		endcase
		v = v + quot[ch][31:0];
		e = longint'(err[ch]) - longint'(incr[ch]);
		if (e < 0) begin
			v = dir[ch] ? v + 32'd1 : v - 32'd1;
			e = e + n;
		end
		lvl[ch] = v;
		err[ch] = e[24:0];
		if (is_last) begin
			done = 1'b1;
		end else if (ch_ctr + 1 >= nch) begin
			ch_ctr = 0;
			frame_ctr = frame_ctr + 24'd1;
		end else begin
			ch_ctr++;
		end
		return 1'b1;
	endfunction

	task automatic send_word(input cmd_t cmd, input logic [2:0] chan,
			input logic [31:0] start_v, input logic [31:0] end_v);
		int unsigned gap;
		result_t r;
		gap = src_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'b0, end_v, start_v, chan};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
		if (ramp_next_sample(cmd, chan, start_v, end_v, r))
			pending_samples.push_back(r);
	endtask

	// Waits until every predicted word has arrived and queued loads have had time to finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_ramp_config(input logic [23:0] frames, input logic [3:0] chans,
			input fmt_t fmt);
		cfg_we <= 1'b1;
		cfg_index <= REG_RAMP_FRAMES;
		cfg_wdata <= frames;
		@(posedge clk);
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_wdata <= {20'h0, chans};
		@(posedge clk);
		cfg_index <= REG_SAMPLE_FORMAT;
		cfg_wdata <= {22'h0, fmt};
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_reg = frames;
		chans_reg = chans;
		fmt_reg = fmt;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t ns: word expected none actual %h last %b", $time, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_samples.pop_front();
				check_field("out_channel", want.out_channel, m_tdata[2:0]);
				check_field("frame_index", want.frame_index, m_tdata[26:3]);
				check_field("sample_value", want.sample_value, m_tdata[58:27]);
				check_field("packed_sample", want.packed_sample, m_tdata[90:59]);
				check_field("byte_count", want.byte_count, m_tdata[93:91]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	initial begin
		int unsigned gap;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = snk_calm ? 0 : $urandom_range(0, 19);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if ($urandom_range(0, 29) == 0)
				snk_calm = !snk_calm;
		end
	end

	function automatic logic [31:0] random_level();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic pick_endpoints(output logic [31:0] a, output logic [31:0] b);
		a = random_level();
		if ($urandom_range(0, 1) == 0)
			b = random_level();
		else
			b = a + 32'($urandom_range(0, 400)) - 32'd200;
	endtask

	task automatic test_emit_before_load();
		set_ramp_config(24'd4, 4'd2, FMT_S16);
		send_word(CMD_EMIT, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
	endtask

	// Loads every channel, several with extreme endpoints, so the full difference range is covered.
	task automatic test_extreme_endpoints();
		set_ramp_config(24'd1, 4'd8, FMT_S32);
		send_word(CMD_LOAD, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(CMD_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(CMD_LOAD, 3'd2, 32'h0000_0000, 32'h0000_0000);
		send_word(CMD_LOAD, 3'd3, 32'hFFFF_FFFF, 32'h0000_0001);
		send_word(CMD_LOAD, 3'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(CMD_LOAD, 3'd5, 32'h0000_8000, 32'hFFFF_0000);
		send_word(CMD_LOAD, 3'd6, 32'h00AB_CDEF, 32'h0000_0000);
		send_word(CMD_LOAD, 3'd7, 32'h8000_0000, 32'h0000_0000);
		repeat (9) send_word(CMD_EMIT, 3'd0, 32'h0, 32'h0);
		drain();
	endtask

	// Zero frames acts as one frame and zero channels as one channel.
	task automatic test_clamped_registers();
		set_ramp_config(24'd0, 4'd0, FMT_S32_IN_24);
		send_word(CMD_LOAD, 3'd0, 32'h1234_5678, 32'h8765_4321);
		send_word(CMD_EMIT, 3'd7, 32'hFFFF_FFFF, 32'h0);
		send_word(CMD_EMIT, 3'd0, 32'h0, 32'hFFFF_FFFF);
		drain();
	endtask

	// Shortens the ramp while it runs, so the current frame becomes the final one.
	task automatic test_midramp_register_change();
		set_ramp_config(24'd5, 4'd15, FMT_S24);
		send_word(CMD_LOAD, 3'd5, 32'd100, 32'hFFFF_FFF9);
		repeat (3) send_word(CMD_EMIT, 3'd0, 32'h0, 32'h0);
		drain();
		set_ramp_config(24'd1, 4'd15, FMT_S32);
		repeat (6) send_word(CMD_EMIT, 3'd0, 32'h0, 32'h0);
		drain();
	endtask

	task automatic test_random_ramps();
		int unsigned n, nch, total, emits;
		logic [31:0] a, b;
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0: n = 0;
				1: n = 24'hFF_FFFF;
				2: n = $urandom_range(65536, 24'hFF_FFFF);
				3: n = $urandom_range(13, 300);
				default: n = $urandom_range(1, 12);
			endcase
			nch = $urandom_range(0, 15);
			drain();
			set_ramp_config(24'(n), 4'(nch), fmt_t'($urandom_range(0, 3)));
			src_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) != 0) begin
				repeat ($urandom_range(1, 3)) begin
					pick_endpoints(a, b);
					send_word(CMD_LOAD, 3'($urandom), a, b);
				end
				total = ((n == 0) ? 1 : n) * ((nch == 0) ? 1 : (nch > MAX_CH) ? MAX_CH : nch);
				emits = ((total > 60) ? 60 : total) + $urandom_range(0, 2);
				repeat (emits) send_word(CMD_EMIT, 3'($urandom), $urandom, $urandom);
			end else begin
				repeat ($urandom_range(1, 10)) begin
					pick_endpoints(a, b);
					send_word(cmd_t'($urandom_range(0, 1)), 3'($urandom), a, b);
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_LOAD;
		cfg_we <= 1'b0;
		cfg_index <= REG_RAMP_FRAMES;
		cfg_wdata <= '0;
		frames_reg = 24'd1;
		chans_reg = 4'd2;
		fmt_reg = FMT_S16;
		frame_ctr = '0;
		ch_ctr = 0;
		done = 1'b1;
		mismatches = 0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_emit_before_load();
		test_extreme_endpoints();
		test_clamped_registers();
		test_midramp_register_change();
		test_random_ramps();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
